@@ rtl/sre_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed radix digit emitter package
// Shared widths, register indexes, sign symbols and the symbol lookup helper.
// ----------------------------------------------------------------------------
`default_nettype none

package sre_pkg;

  // Field and register widths
  localparam int unsigned ValueW     = 32;
  localparam int unsigned SymW       = 8;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned RadixW     = 5;
  localparam int unsigned MaxSymbols = 16;
  localparam int unsigned SymIdxW    = $clog2(MaxSymbols);
  localparam int unsigned AlphaW     = MaxSymbols * SymW;

  // Digit store: a 32-bit magnitude has at most 32 digits in radix 2
  localparam int unsigned MaxDigits  = ValueW;
  localparam int unsigned DigitIdxW  = $clog2(MaxDigits);
  localparam int unsigned DigitCntW  = DigitIdxW + 1;

  // Divider: quotient bits resolved per cycle
  localparam int unsigned DivBitsPerCycle = 8;
  localparam int unsigned DivCycles       = ValueW / DivBitsPerCycle;
  localparam int unsigned DivCntW         = $clog2(DivCycles);

  // Sign symbols
  localparam logic [SymW-1:0] PlusSym  = 8'h2B;
  localparam logic [SymW-1:0] MinusSym = 8'h2D;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SYMBOLS_LOW  = 2'd0,
    REG_SYMBOLS_HIGH = 2'd1,
    REG_RADIX        = 2'd2
  } cfg_reg_e;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] dividend;
    logic [RadixW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ValueW-1:0]  quot;
    logic [SymIdxW-1:0] rem;
  } div_rsp_t;

  // Alphabet check response
  typedef struct packed {
    logic done;
    logic ok;
  } chk_rsp_t;

  // Pick symbol idx out of the packed alphabet, symbol 0 in the lowest byte
  function automatic logic [SymW-1:0] sym_at(input logic [AlphaW-1:0]  alpha,
                                             input logic [SymIdxW-1:0] idx);
    sym_at = alpha[idx*SymW +: SymW];
  endfunction

endpackage

`default_nettype wire

@@ rtl/sre_in_if.sv @@
// ----------------------------------------------------------------------------
// Signed radix digit emitter input channel
// Valid/ready channel carrying one signed value per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sre_in_if;
  import sre_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source  (output valid, output value, input ready);
  modport sink    (input valid, input value, output ready);
  modport monitor (input valid, input value, input ready);
endinterface

`default_nettype wire

@@ rtl/sre_out_if.sv @@
// ----------------------------------------------------------------------------
// Signed radix digit emitter output channel
// Valid/ready channel carrying one symbol byte and a last flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sre_out_if;
  import sre_pkg::*;

  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            last;

  modport source  (output valid, output symbol, output last, input ready);
  modport sink    (input valid, input symbol, input last, output ready);
  modport monitor (input valid, input symbol, input last, input ready);
endinterface

`default_nettype wire

@@ rtl/sre_alpha_check.sv @@
// ----------------------------------------------------------------------------
// Alphabet checker
// Scans the symbols in use one per cycle, rejecting sign symbols, repeats
// and radices outside 2..16.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_alpha_check (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [sre_pkg::AlphaW-1:0] alpha_i,
  input  wire logic [sre_pkg::RadixW-1:0] radix_i,
  output sre_pkg::chk_rsp_t              rsp_o
);
  import sre_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               ok_q, ok_d;
  logic [SymIdxW-1:0] idx_q, idx_d;

  logic               radix_bad;
  logic [SymIdxW-1:0] idx_last;
  logic [SymW-1:0]    cur_sym;
  logic               cur_bad;

  assign radix_bad = (radix_i < RadixW'(2)) || (radix_i > RadixW'(MaxSymbols));
  assign idx_last  = SymIdxW'(radix_i - RadixW'(1));
  assign cur_sym   = sym_at(alpha_i, idx_q);

  // Compare the current symbol against the signs and every later symbol in use
  always_comb begin
    cur_bad = (cur_sym == PlusSym) || (cur_sym == MinusSym);
    for (int j = 0; j < MaxSymbols; j++) begin
      if ((RadixW'(j) > RadixW'(idx_q)) && (RadixW'(j) < radix_i) &&
          (sym_at(alpha_i, SymIdxW'(j)) == cur_sym)) begin
        cur_bad = 1'b1;
      end
    end
  end

  // Advance the scan
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ok_d   = ok_q;
    idx_d  = idx_q;
    if (start_i) begin
      idx_d = '0;
      if (radix_bad) begin
        done_d = 1'b1;
        ok_d   = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (cur_bad) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        ok_d   = 1'b0;
      end else if (idx_q == idx_last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        ok_d   = 1'b1;
      end else begin
        idx_d = idx_q + SymIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ok_q   <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ok_q   <= ok_d;
      idx_q  <= idx_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ok   = ok_q;

endmodule

`default_nettype wire

@@ rtl/sre_div_unit.sv @@
// ----------------------------------------------------------------------------
// Radix divider
// Restoring division of a 32-bit magnitude by a radix of 2..16, resolving
// eight quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_div_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sre_pkg::div_req_t req_i,
  output sre_pkg::div_rsp_t      rsp_o
);
  import sre_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [ValueW-1:0]  dvd_q;
  logic [ValueW-1:0]  quot_q;
  logic [SymIdxW-1:0] rem_q;
  logic [RadixW-1:0]  div_q;

  logic [SymIdxW-1:0]         rem_d;
  logic [DivBitsPerCycle-1:0] qbits;

  // Resolve one byte of quotient bits, most significant first
  always_comb begin
    logic [RadixW-1:0]          t;
    logic [DivBitsPerCycle-1:0] src;
    src   = dvd_q[ValueW-1 -: DivBitsPerCycle];
    rem_d = rem_q;
    qbits = '0;
    for (int b = DivBitsPerCycle - 1; b >= 0; b--) begin
      t = {rem_d, src[b]};
      if (t >= div_q) begin
        rem_d    = SymIdxW'(t - div_q);
        qbits[b] = 1'b1;
      end else begin
        rem_d = t[SymIdxW-1:0];
      end
    end
  end

  // Control: load on start, count the passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend out, the quotient in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q  <= req_i.dividend;
      div_q  <= req_i.divisor;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= dvd_q << DivBitsPerCycle;
      rem_q  <= rem_d;
      quot_q <= {quot_q[ValueW-DivBitsPerCycle-1:0], qbits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ rtl/signed_radix_digit_emitter_core.sv @@
// ----------------------------------------------------------------------------
// Signed radix digit emitter
// Formats a signed 32-bit value as symbols of a configured alphabet,
// leading minus first, then digits most significant first.
// ----------------------------------------------------------------------------
// An accepted value first has its alphabet scanned, one symbol per cycle (a
// radix outside 2..16 is rejected without a scan; a rejected alphabet gives
// no beats). Digits are then produced least significant first by one shared
// divider that resolves 8 quotient bits a cycle, and the number of digits
// is set by the magnitude and radix (up to 32). One sign step follows,
// whether or not a minus beat is sent, and symbols then leave one per cycle
// from the digit store while the sink keeps ready high. An item with a usable
// alphabet keeps input ready low through its check, division, sign and emit
// steps and any sink stalls; input ready is high only between items, and the
// last beat of one item may still wait in the output register while the next
// value is taken. Configuration may be written only while no item is in
// flight.
`default_nettype none

module signed_radix_digit_emitter_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sre_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sre_pkg::CfgDataW-1:0] cfg_data_i,
  sre_in_if.sink                            in_i,
  sre_out_if.source                         out_o
);
  import sre_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Configuration registers
  logic [CfgDataW-1:0] sym_lo_q, sym_hi_q;
  logic [RadixW-1:0]   radix_q;
  logic [AlphaW-1:0]   alpha;

  // Sequencer state
  state_e               state_q, state_d;
  logic                 neg_q, neg_d;
  logic [ValueW-1:0]    mag_q, mag_d;
  logic [DigitIdxW-1:0] nd_q, nd_d;
  logic [DigitIdxW-1:0] k_q, k_d;
  logic                 out_valid_q, out_valid_d;
  logic [SymW-1:0]      out_sym_q, out_sym_d;
  logic                 out_last_q, out_last_d;

  // Digit store
  logic [SymIdxW-1:0]   digits_q [MaxDigits];
  logic                 dig_we;

  logic      in_acc;
  logic      slot_free;
  logic      chk_start;
  chk_rsp_t  chk_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign alpha     = {sym_hi_q, sym_lo_q};
  assign in_acc    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo_q <= '0;
      sym_hi_q <= '0;
      radix_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SYMBOLS_LOW:  sym_lo_q <= cfg_data_i;
        REG_SYMBOLS_HIGH: sym_hi_q <= cfg_data_i;
        REG_RADIX:        radix_q  <= cfg_data_i[RadixW-1:0];
        default:          ;
      endcase
    end
  end

  sre_alpha_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (chk_start),
    .alpha_i (alpha),
    .radix_i (radix_q),
    .rsp_o   (chk_rsp)
  );

  sre_div_unit u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequence check, division and emission
  always_comb begin
    state_d          = state_q;
    neg_d            = neg_q;
    mag_d            = mag_q;
    nd_d             = nd_q;
    k_d              = k_q;
    out_valid_d      = out_valid_q && !out_o.ready;
    out_sym_d        = out_sym_q;
    out_last_d       = out_last_q;
    chk_start        = 1'b0;
    dig_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = (state_q == ST_CHECK) ? mag_q : div_rsp.quot;
    div_req.divisor  = radix_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_d     = in_i.value[ValueW-1];
          mag_d     = in_i.value[ValueW-1] ? ValueW'(-in_i.value) : ValueW'(in_i.value);
          chk_start = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_rsp.done) begin
          if (chk_rsp.ok) begin
            nd_d          = '0;
            div_req.start = 1'b1;
            state_d       = ST_DIV;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          dig_we = 1'b1;
          nd_d   = nd_q + DigitIdxW'(1);
          if ((div_rsp.quot == '0) || (nd_q == DigitIdxW'(MaxDigits - 1))) begin
            k_d     = nd_q;
            state_d = ST_SIGN;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (!neg_q) begin
          state_d = ST_EMIT;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = MinusSym;
          out_last_d  = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = sym_at(alpha, digits_q[k_q]);
          out_last_d  = (k_q == '0);
          if (k_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q - DigitIdxW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_sym_q   <= '0;
      out_last_q  <= 1'b0;
      nd_q        <= '0;
      k_q         <= '0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_sym_q   <= out_sym_d;
      out_last_q  <= out_last_d;
      nd_q        <= nd_d;
      k_q         <= k_d;
      neg_q       <= neg_d;
      mag_q       <= mag_d;
    end
  end

  // Store each remainder as it comes out of the divider
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digits_q[nd_q] <= div_rsp.rem;
    end
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.symbol = out_sym_q;
  assign out_o.last   = out_last_q;

endmodule

`default_nettype wire

@@ rtl/sre_checker.sv @@
// ----------------------------------------------------------------------------
// Signed radix digit emitter port checker
// Watches the channels of the top level and flags sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [sre_pkg::SymW-1:0]  out_symbol_i,
  input wire logic                      out_last_i
);
  import sre_pkg::*;

  // A stalled output beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_symbol_i) && $stable(out_last_i))
    else $error("output beat dropped or changed while stalled");

  // An accepted value keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again straight after a value");

  // A minus beat never closes a number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_symbol_i == MinusSym) |-> !out_last_i)
    else $error("minus symbol flagged as last");

  // A minus beat is always followed straight away by a digit beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (out_symbol_i == MinusSym) |=> out_valid_i)
    else $error("no digit beat right after a minus beat");

endmodule

bind signed_radix_digit_emitter_core sre_checker u_sre_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_symbol_i (out_o.symbol),
  .out_last_i   (out_o.last)
);

`default_nettype wire
